// ----- design/rdq_pkg.sv -----
package rdq_pkg;

   localparam int DefQueueDepth = 16;
   localparam int DefArgBits    = 32;

   localparam int CODE_BITS    = 8;
   localparam int IN_ARG_BITS  = 32;
   localparam int OUT_ARG_BITS = 32;

   // code returned by a take from an empty queue ('q')
   localparam logic [CODE_BITS-1:0] CODE_EMPTY = 8'd113;

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_PUSH   = 2'd1,
      FUNC_TAKE   = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

endpackage

// ----- design/ring_deque_instruction_queue.sv -----
// channel  dir  tdata (low bit up)                        tuser
// req_     in   in_code[7:0] in_arg[39:8]                 func[1:0]
// rsp_     out  out_code[7:0] out_arg[39:8] now_empty[40]  status[1:0]
//
// one transaction accepted per cycle while req_tready is high; its result
// passes through the first stage (state update and entry read), then the
// result register, and is valid once held in the result register
// the latency is set by the registered read port of the entry memory
// reset clears pointers to depth minus one, sets the empty flag and drops
// both pipeline stages; entry memory is not cleared
// a stalled result holds; the input side keeps accepting while a slot is free
module ring_deque_instruction_queue import rdq_pkg::*; #(
   parameter int QUEUE_DEPTH = DefQueueDepth,
   parameter int ARG_BITS    = DefArgBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // in_code[7:0], in_arg[39:8]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_code[7:0], out_arg[39:8], now_empty[40], zero
   output logic [1:0]  rsp_tuser    // status[1:0]
);

   localparam int IDX_W    = $clog2(QUEUE_DEPTH);
   localparam int ARG_KEEP = (ARG_BITS < IN_ARG_BITS) ? ARG_BITS : IN_ARG_BITS;
   localparam int DATA_W   = CODE_BITS + ARG_KEEP;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

   function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_LAST : i - 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i);
      return (i == IDX_LAST) ? '0 : i + 1'b1;
   endfunction

   // queue state
   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] back_ff, back_in;
   logic             empty_ff, empty_in;

   // first stage: decision made, entry read in flight
   logic       s1_valid_ff;
   status_type s1_status_ff, s1_status_in;
   logic       s1_take_ff, s1_take_in;
   logic       s1_empty_ff;

   // result register
   logic                    out_valid_ff;
   status_type              out_status_ff;
   logic [CODE_BITS-1:0]    out_code_ff;
   logic [OUT_ARG_BITS-1:0] out_arg_ff;
   logic                    out_empty_ff;

   func_type             req_func;
   logic [CODE_BITS-1:0] req_code;
   logic [ARG_KEEP-1:0]  req_arg;
   logic                 req_accept;
   logic                 out_free;
   logic                 s1_move;
   logic                 full;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [DATA_W-1:0]    rd_data;
   logic [ARG_KEEP-1:0]  rd_arg;

   assign req_func = func_type'(req_tuser);
   assign req_code = req_tdata[CODE_BITS-1:0];
   assign req_arg  = req_tdata[CODE_BITS +: ARG_KEEP];

   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   assign full = !empty_ff && (front_ff == back_ff);

   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      empty_in     = empty_ff;
      s1_status_in = STATUS_OK;
      s1_take_in   = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = back_ff;
      unique case (req_func)
         FUNC_APPEND: begin
            if (full) begin
               s1_status_in = STATUS_FULL;
            end else begin
               wr_en    = req_accept;
               wr_addr  = back_ff;
               back_in  = idx_down(back_ff);
               empty_in = 1'b0;
            end
         end
         FUNC_PUSH: begin
            if (full) begin
               s1_status_in = STATUS_FULL;
            end else begin
               wr_en    = req_accept;
               wr_addr  = idx_up(front_ff);
               front_in = idx_up(front_ff);
               empty_in = 1'b0;
            end
         end
         FUNC_TAKE: begin
            if (empty_ff) begin
               s1_status_in = STATUS_EMPTY;
            end else begin
               s1_take_in = 1'b1;
               front_in   = idx_down(front_ff);
               empty_in   = (idx_down(front_ff) == back_ff);
            end
         end
         FUNC_CLEAR: begin
            front_in = IDX_LAST;
            back_in  = IDX_LAST;
            empty_in = 1'b1;
         end
         default: begin
            front_in = front_ff;
         end
      endcase
   end

   rdq_store #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (DATA_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_arg, req_code}),
      .rd_en   (req_accept),
      .rd_addr (front_ff),
      .rd_data (rd_data)
   );

   assign rd_arg = rd_data[CODE_BITS +: ARG_KEEP];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff    <= IDX_LAST;
         back_ff     <= IDX_LAST;
         empty_ff    <= 1'b1;
         s1_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            front_ff <= front_in;
            back_ff  <= back_in;
            empty_ff <= empty_in;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_status_ff <= s1_status_in;
         s1_take_ff   <= s1_take_in;
         s1_empty_ff  <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_status_ff <= s1_status_ff;
         out_empty_ff  <= s1_empty_ff;
         if (s1_take_ff) begin
            out_code_ff <= rd_data[CODE_BITS-1:0];
            out_arg_ff  <= OUT_ARG_BITS'(rd_arg);
         end else begin
            out_code_ff <= (s1_status_ff == STATUS_EMPTY) ? CODE_EMPTY : '0;
            out_arg_ff  <= '0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_empty_ff, out_arg_ff, out_code_ff};
   assign rsp_tuser  = out_status_ff;

   // equal pointers with the empty flag set is the only empty encoding
   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (front_ff == back_ff))
      else $error("empty flag set with unequal pointers");

   // a clear leaves both pointers at the last slot and reports empty
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_func == FUNC_CLEAR) |=>
         (front_ff == IDX_LAST && back_ff == IDX_LAST && s1_valid_ff && s1_empty_ff))
      else $error("clear did not reset the queue");

   // a take from an empty queue returns the empty code and no argument
   a_empty_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == STATUS_EMPTY) |->
         (out_code_ff == CODE_EMPTY && out_arg_ff == '0 && out_empty_ff))
      else $error("bad result for take from empty queue");

   // a dropped push or append never touches the entry memory
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_accept && full && (req_func == FUNC_APPEND || req_func == FUNC_PUSH)) |->
         !wr_en)
      else $error("write issued on a full queue");

endmodule

// ----- design/rdq_store.sv -----
module rdq_store import rdq_pkg::*; #(
   parameter int DEPTH  = DefQueueDepth,
   parameter int DATA_W = CODE_BITS + DefArgBits
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read returns contents from before any write at the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
